>>> rtl/core/rsmp_pkg.sv
// ----------------------------------------------------------------------------
// rsmp_pkg: shared types and constants of the stereo resampler
// Sample, phase and step formats, register map and the types carried between
// the front end, the frame queue and the interpolation back end.
// ----------------------------------------------------------------------------
package rsmp_pkg;

    // Q2.16 samples, limited to +-2.0
    localparam int SAMPLE_W = 19;
    // Q4.16 read phase, held to 20 bits
    localparam int PHASE_W = 20;
    localparam int STEP_W = 19;
    localparam int FRAC_W = 16;
    localparam int OUT_W = 16;

    localparam logic [PHASE_W-1:0] ONE_Q16 = PHASE_W'(65536);
    localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(4096);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(262144);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    localparam int MAX_RESULTS = 16;
    localparam int COUNT_W = $clog2(MAX_RESULTS);

    localparam int QUEUE_DEPTH_DEF = 2;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_SOURCE_IS_FLOAT = 2'd0;
    localparam logic [1:0] REG_SOURCE_IS_MONO = 2'd1;
    localparam logic [1:0] REG_STEP_RATIO = 2'd2;

    typedef struct packed {
        logic is_float;
        logic is_mono;
        logic [STEP_W-1:0] step;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } frame_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

endpackage

>>> rtl/core/rsmp_front.sv
// ----------------------------------------------------------------------------
// rsmp_front: input beat acceptance and sample decoding
// Decodes float32 or signed 16-bit samples to Q2.16 and pushes the frame
// into the queue.
// ----------------------------------------------------------------------------
module rsmp_front
    import rsmp_pkg::*;
(
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [31:0] left_sample,
    input  logic [31:0] right_sample,
    input  logic        queue_full,
    output logic        queue_push,
    output frame_t      queue_frame
);

    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_SAT = 8'd134;
    localparam logic [SAMPLE_W-2:0] SAMPLE_LIMIT = (SAMPLE_W-1)'(131072);

    function automatic logic signed [SAMPLE_W-1:0] decode_s16(input logic [31:0] v);
        return {{(SAMPLE_W-17){v[15]}}, v[15:0], 1'b0};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] decode_f32(input logic [31:0] bits);
        logic [7:0] expo;
        logic [23:0] mant;
        logic [7:0] rsh;
        logic [23:0] shifted;
        logic [SAMPLE_W-2:0] mag;
        logic signed [SAMPLE_W-1:0] smag;
        expo = bits[30:23];
        mant = 24'd0;
        rsh = 8'd0;
        shifted = 24'd0;
        if (expo == EXP_SPECIAL) begin
            // NaN decodes as zero, infinity saturates by sign
            mag = (bits[22:0] != 23'd0) ? '0 : SAMPLE_LIMIT;
        end
        else if (expo >= EXP_SAT) begin
            mag = SAMPLE_LIMIT;
        end
        else begin
            if (expo == 8'd0) begin
                mant = {1'b0, bits[22:0]};
                rsh = EXP_SAT - 8'd1;
            end
            else begin
                mant = {1'b1, bits[22:0]};
                rsh = EXP_SAT - expo;
            end
            shifted = mant >> rsh;
            mag = (shifted > 24'(SAMPLE_LIMIT)) ? SAMPLE_LIMIT : shifted[SAMPLE_W-2:0];
        end
        smag = signed'({1'b0, mag});
        return bits[31] ? -smag : smag;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] decode(input logic is_float,
                                                         input logic [31:0] v);
        return is_float ? decode_f32(v) : decode_s16(v);
    endfunction

    logic signed [SAMPLE_W-1:0] left_dec;
    logic signed [SAMPLE_W-1:0] right_dec;

    assign left_dec = decode(cfg.is_float, left_sample);
    assign right_dec = cfg.is_mono ? left_dec : decode(cfg.is_float, right_sample);

    assign sample_ready = ~queue_full & rst_n;
    assign queue_push = sample_valid & sample_ready;
    assign queue_frame = '{left: left_dec, right: right_dec};

endmodule

>>> rtl/core/rsmp_queue.sv
// ----------------------------------------------------------------------------
// rsmp_queue: short frame queue between front and back end
// Register-based first-in first-out store of decoded frames.
// ----------------------------------------------------------------------------
module rsmp_queue
    import rsmp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output frame_t head_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_frame = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

>>> rtl/core/rsmp_back.sv
// ----------------------------------------------------------------------------
// rsmp_back: phase sequencer and interpolation pipeline
// Walks the read phase across one frame interval, issuing one interpolated
// output frame per cycle unless held, via a multiply and an output stage.
// ----------------------------------------------------------------------------
module rsmp_back
    import rsmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    head_valid,
    input  frame_t                  head_frame,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [OUT_W-1:0] out_left,
    output logic signed [OUT_W-1:0] out_right,
    output logic                    last_of_run
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int SCALED_W = PROD_W + 16;
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(MAX_RESULTS - 1);
    localparam logic [20:0] POS_MAX = 21'd32767;
    localparam logic [20:0] NEG_MAX = 21'd32768;

    function automatic logic [PHASE_W-1:0] wrap_phase(input logic [PHASE_W-1:0] p);
        return (p >= ONE_Q16) ? p - ONE_Q16 : '0;
    endfunction

    // base*2^16 + product, times 32767, truncated toward zero, saturated
    function automatic logic signed [OUT_W-1:0] scale_out(
        input logic signed [SAMPLE_W-1:0] base,
        input logic signed [PROD_W-1:0] prod);
        logic signed [SCALED_W-1:0] acc;
        logic signed [SCALED_W-1:0] scaled;
        logic [SCALED_W-1:0] mag_full;
        logic [20:0] mag;
        logic signed [OUT_W-1:0] r;
        acc = {{(SCALED_W-SAMPLE_W-16){base[SAMPLE_W-1]}}, base, 16'd0}
            + {{(SCALED_W-PROD_W){prod[PROD_W-1]}}, prod};
        scaled = (acc <<< 15) - acc;
        mag_full = scaled[SCALED_W-1] ? -scaled : scaled;
        mag = mag_full[52:32];
        if (scaled[SCALED_W-1])
            r = (mag > NEG_MAX) ? -16'sd32768 : signed'(16'(-mag[15:0]));
        else
            r = (mag > POS_MAX) ? 16'sd32767 : signed'(mag[15:0]);
        return r;
    endfunction

    back_state_t state_reg, state_next;
    logic have_prev_reg, have_prev_next;
    logic signed [SAMPLE_W-1:0] prev_l_reg, prev_l_next;
    logic signed [SAMPLE_W-1:0] prev_r_reg, prev_r_next;
    logic signed [SAMPLE_W-1:0] cur_l_reg, cur_l_next;
    logic signed [SAMPLE_W-1:0] cur_r_reg, cur_r_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic m_valid_reg;
    logic m_last_reg;
    logic signed [PROD_W-1:0] m_prod_l_reg, m_prod_r_reg;
    logic signed [SAMPLE_W-1:0] m_base_l_reg, m_base_r_reg;

    logic o_valid_reg;
    logic o_last_reg;
    logic signed [OUT_W-1:0] o_left_reg, o_right_reg;

    logic advance;
    logic issue;
    logic issue_last;
    logic [STEP_W-1:0] step;
    logic [PHASE_W-1:0] phase_sum;
    logic signed [DIFF_W-1:0] diff_l, diff_r;
    logic signed [FRAC_W:0] frac;
    logic signed [PROD_W-1:0] prod_l, prod_r;

    // Advance the pipeline unless the output beat is held
    assign advance = ~o_valid_reg | result_ready;

    always_comb
    begin
        if (cfg.step < STEP_MIN)
            step = STEP_MIN;
        else if (cfg.step > STEP_MAX)
            step = STEP_MAX;
        else
            step = cfg.step;
    end

    assign phase_sum = phase_reg + PHASE_W'(step);
    assign issue_last = (phase_sum >= ONE_Q16) || (count_reg == LAST_COUNT);

    assign diff_l = DIFF_W'(cur_l_reg) - DIFF_W'(prev_l_reg);
    assign diff_r = DIFF_W'(cur_r_reg) - DIFF_W'(prev_r_reg);
    assign frac = signed'({1'b0, phase_reg[FRAC_W-1:0]});
    assign prod_l = diff_l * frac;
    assign prod_r = diff_r * frac;

    always_comb
    begin
        state_next = state_reg;
        have_prev_next = have_prev_reg;
        prev_l_next = prev_l_reg;
        prev_r_next = prev_r_reg;
        cur_l_next = cur_l_reg;
        cur_r_next = cur_r_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        pop = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (have_prev_reg)
                    begin
                        cur_l_next = head_frame.left;
                        cur_r_next = head_frame.right;
                        count_next = '0;
                        state_next = BACK_RUN;
                    end
                    else
                    begin
                        // First frame: store only, phase untouched
                        prev_l_next = head_frame.left;
                        prev_r_next = head_frame.right;
                        have_prev_next = 1'b1;
                    end
                end
            end
            BACK_RUN:
            begin
                if (phase_reg >= ONE_Q16)
                begin
                    // No output position in this interval
                    phase_next = wrap_phase(phase_reg);
                    prev_l_next = cur_l_reg;
                    prev_r_next = cur_r_reg;
                    state_next = BACK_IDLE;
                end
                else if (advance)
                begin
                    issue = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (issue_last)
                    begin
                        phase_next = wrap_phase(phase_sum);
                        prev_l_next = cur_l_reg;
                        prev_r_next = cur_r_reg;
                        state_next = BACK_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_sum;
                    end
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            have_prev_reg <= 1'b0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            phase_reg <= '0;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            have_prev_reg <= have_prev_next;
            prev_l_reg <= prev_l_next;
            prev_r_reg <= prev_r_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            if (advance)
            begin
                m_valid_reg <= issue;
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
        if (advance)
        begin
            m_prod_l_reg <= prod_l;
            m_prod_r_reg <= prod_r;
            m_base_l_reg <= prev_l_reg;
            m_base_r_reg <= prev_r_reg;
            m_last_reg <= issue_last;
            o_left_reg <= scale_out(m_base_l_reg, m_prod_l_reg);
            o_right_reg <= scale_out(m_base_r_reg, m_prod_r_reg);
            o_last_reg <= m_last_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign out_left = o_left_reg;
    assign out_right = o_right_reg;
    assign last_of_run = o_last_reg;

endmodule

>>> rtl/core/linear_interp_stereo_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_stereo_resampler: linear interpolation resampler to 48 kHz
// APB configuration, input decoding, frame queue and interpolation back end.
// ----------------------------------------------------------------------------
// Each input beat carries one source frame (float32 bit patterns or signed
// 16-bit samples; in mono mode the left sample feeds both channels). The
// block decodes it to Q2.16, keeps the previous frame and a Q4.16 read
// phase, and emits one output beat for every 48 kHz position between the
// previous and the current frame, linearly interpolated per channel, scaled
// by 32767, truncated toward zero and saturated to signed 16 bits. The last
// output beat caused by an input frame has last_of_run set; a frame may cause
// none (the very first frame never does, and a step above 1.0 may skip one).
// Sequence: the back end loads a frame, then issues one output beat per cycle
// while the output beat is not held; a frame with no outputs takes a skip
// step instead, and the very first frame is only stored. Beats issued by the
// single interpolation lane pass its multiply and output registers. The
// front end keeps taking input beats into a short queue while the back end
// works or while an output beat waits, so up to QUEUE_DEPTH frames may be
// buffered.
// Registers (APB, byte address 4*i): 0 source_is_float, 1 source_is_mono,
// 2 step_ratio (source rate / 48000 in Q3.16, clamped to 1/16 .. 4).
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module linear_interp_stereo_resampler
    import rsmp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    // input frames
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic [31:0]             left_sample,
    input  logic [31:0]             right_sample,
    // output frames
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [OUT_W-1:0] out_left,
    output logic signed [OUT_W-1:0] out_right,
    output logic                    last_of_run
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_write;
    logic [1:0] reg_index;

    logic queue_full;
    logic queue_push;
    frame_t queue_frame;
    logic queue_pop;
    logic head_valid;
    frame_t head_frame;

    // Register writes land on the access phase of the APB transfer
    assign pready = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_SOURCE_IS_FLOAT: cfg_next.is_float = pwdata[0];
                REG_SOURCE_IS_MONO:  cfg_next.is_mono = pwdata[0];
                REG_STEP_RATIO:      cfg_next.step = pwdata[STEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{is_float: 1'b0, is_mono: 1'b0, step: STEP_RESET};
        else
            cfg_reg <= cfg_next;
    end

    // Read back: unused addresses return zero
    always_comb
    begin
        unique case (reg_index)
            REG_SOURCE_IS_FLOAT: prdata = DATA_W'(cfg_reg.is_float);
            REG_SOURCE_IS_MONO:  prdata = DATA_W'(cfg_reg.is_mono);
            REG_STEP_RATIO:      prdata = DATA_W'(cfg_reg.step);
            default:             prdata = '0;
        endcase
    end

    // Decode and push each accepted frame
    rsmp_front u_front (
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .queue_full   (queue_full),
        .queue_push   (queue_push),
        .queue_frame  (queue_frame)
    );

    // Decouple intake from interpolation
    rsmp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_frame (queue_frame),
        .full       (queue_full),
        .pop        (queue_pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    // Walk the phase and emit interpolated frames
    rsmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_frame   (head_frame),
        .pop          (queue_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_left     (out_left),
        .out_right    (out_right),
        .last_of_run  (last_of_run)
    );

endmodule
